// ===== hw/rtl/srfp_pkg.sv =====
// Package for the servo reply frame parser: constants, codes and shared types.
`default_nettype none
package srfp_pkg;

    localparam int SERVO_CHANNELS  = 16;
    localparam int MAX_FRAME_BYTES = 64;

    localparam int ID_IDX_W  = (SERVO_CHANNELS > 1) ? $clog2(SERVO_CHANNELS) : 1;
    localparam int COUNT_W   = 6;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    // Frame totals count header, id and length bytes on top of the length field.
    localparam logic [8:0] FRAME_OVERHEAD = 9'd4;
    localparam logic [8:0] MIN_TOTAL      = 9'd6;
    localparam logic [8:0] MAX_TOTAL      = 9'(MAX_FRAME_BYTES);
    localparam logic [8:0] ACK_TOTAL      = 9'd6;
    localparam logic [8:0] POS_TOTAL      = 9'd8;

    localparam logic [PADDR_W-3:0] REG_EXPECTED_REPLY = '0;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_BODY  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REPLY_PING   = 2'd0,
        REPLY_ACK    = 2'd1,
        REPLY_POS    = 2'd2,
        REPLY_UNUSED = 2'd3
    } t_reply;

    typedef enum logic [2:0] {
        ST_POS_OK    = 3'd0,
        ST_ACK_OK    = 3'd1,
        ST_PING      = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CSUM  = 3'd4,
        ST_BAD_ID    = 3'd5,
        ST_OVERSIZE  = 3'd6
    } t_status;

    typedef struct packed {
        logic               valid;
        logic [2:0]         status;
        logic [7:0]         servo_id;
        logic [7:0]         error_bits;
        logic signed [15:0] position;
        logic               new_servo;
        logic [COUNT_W-1:0] servo_total;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/srfp_if.sv =====
// Stream interfaces for received bytes and status results.
`default_nettype none
interface srfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       flush;

    modport source (output valid, output rx_byte, output flush, input ready);
    modport sink   (input valid, input rx_byte, input flush, output ready);
endinterface

interface srfp_status_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [7:0]                  servo_id;
    logic [7:0]                  error_bits;
    logic signed [15:0]          position;
    logic                        new_servo;
    logic [srfp_pkg::COUNT_W-1:0] servo_total;

    modport source (output valid, output status, output servo_id, output error_bits,
                    output position, output new_servo, output servo_total, input ready);
    modport sink   (input valid, input status, input servo_id, input error_bits,
                    input position, input new_servo, input servo_total, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/srfp_parser.sv =====
// Frame parsing state, checksum, id tracking and per-byte status decision.
`default_nettype none
module srfp_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_flush,
    input  wire logic [1:0]        i_expected,
    output srfp_pkg::t_result      o_result
);

    srfp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_ident, n_ident;
    logic [7:0] r_length, n_length;
    logic [7:0] r_index, n_index;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_status_byte, n_status_byte;
    logic [7:0] r_pos_lo, n_pos_lo;
    logic [7:0] r_pos_hi, n_pos_hi;
    logic [srfp_pkg::SERVO_CHANNELS-1:0] r_seen, n_seen;
    logic [srfp_pkg::COUNT_W-1:0] r_count, n_count;

    logic [8:0]  len_total;
    logic [8:0]  frame_total;
    logic [7:0]  id_minus1;
    logic [srfp_pkg::ID_IDX_W-1:0] id_idx;
    logic        id_ok;
    logic        fresh;
    logic [14:0] pos_mag;
    logic [15:0] pos_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= srfp_pkg::PH_HUNT1;
            r_ident       <= '0;
            r_length      <= '0;
            r_index       <= '0;
            r_sum         <= '0;
            r_status_byte <= '0;
            r_pos_lo      <= '0;
            r_pos_hi      <= '0;
            r_seen        <= '0;
            r_count       <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_ident       <= n_ident;
            r_length      <= n_length;
            r_index       <= n_index;
            r_sum         <= n_sum;
            r_status_byte <= n_status_byte;
            r_pos_lo      <= n_pos_lo;
            r_pos_hi      <= n_pos_hi;
            r_seen        <= n_seen;
            r_count       <= n_count;
        end
    end

    assign len_total   = {1'b0, i_byte} + srfp_pkg::FRAME_OVERHEAD;
    assign frame_total = {1'b0, r_length} + srfp_pkg::FRAME_OVERHEAD;
    assign id_minus1   = r_ident - 8'd1;
    assign id_idx      = id_minus1[srfp_pkg::ID_IDX_W-1:0];
    assign id_ok       = (r_ident != 8'd0) && ({1'b0, r_ident} <= 9'(srfp_pkg::SERVO_CHANNELS));
    assign fresh       = !r_seen[id_idx];
    assign pos_mag     = {r_pos_hi[6:0], r_pos_lo};
    // Sign-magnitude to two's complement; a negative zero stays zero.
    assign pos_val     = r_pos_hi[7] ? (16'd0 - {1'b0, pos_mag}) : {1'b0, pos_mag};

    always_comb begin
        n_phase       = r_phase;
        n_ident       = r_ident;
        n_length      = r_length;
        n_index       = r_index;
        n_sum         = r_sum;
        n_status_byte = r_status_byte;
        n_pos_lo      = r_pos_lo;
        n_pos_hi      = r_pos_hi;
        n_seen        = r_seen;
        n_count       = r_count;

        o_result             = '0;
        o_result.servo_id    = r_ident;
        o_result.servo_total = r_count;

        if (i_flush) begin
            n_phase = srfp_pkg::PH_HUNT1;
            n_index = '0;
            n_sum   = '0;
        end else begin
            unique case (r_phase)
                srfp_pkg::PH_HUNT1: begin
                    if (i_byte == srfp_pkg::HEADER_BYTE) begin
                        n_phase = srfp_pkg::PH_HUNT2;
                    end
                end
                srfp_pkg::PH_HUNT2: begin
                    n_phase = (i_byte == srfp_pkg::HEADER_BYTE) ? srfp_pkg::PH_ID
                                                                : srfp_pkg::PH_HUNT1;
                end
                srfp_pkg::PH_ID: begin
                    n_ident = i_byte;
                    n_sum   = i_byte;
                    n_phase = srfp_pkg::PH_LEN;
                end
                srfp_pkg::PH_LEN: begin
                    n_length = i_byte;
                    n_sum    = r_sum + i_byte;
                    o_result.servo_id = r_ident;
                    if (len_total > srfp_pkg::MAX_TOTAL) begin
                        n_phase = srfp_pkg::PH_HUNT1;
                        n_index = '0;
                        n_sum   = '0;
                        o_result.valid  = 1'b1;
                        o_result.status = srfp_pkg::ST_OVERSIZE;
                    end else if (len_total < srfp_pkg::MIN_TOTAL) begin
                        n_phase = srfp_pkg::PH_HUNT1;
                        n_index = '0;
                        n_sum   = '0;
                        o_result.valid  = 1'b1;
                        o_result.status = srfp_pkg::ST_BAD_LEN;
                    end else begin
                        n_index = '0;
                        n_phase = srfp_pkg::PH_BODY;
                    end
                end
                srfp_pkg::PH_BODY: begin
                    if ({1'b0, r_index} + 9'd1 >= {1'b0, r_length}) begin
                        // Check byte: the frame ends here whatever the outcome.
                        n_phase = srfp_pkg::PH_HUNT1;
                        n_index = '0;
                        n_sum   = '0;
                        o_result.valid = 1'b1;
                        if (i_byte != ~r_sum) begin
                            o_result.status = srfp_pkg::ST_BAD_CSUM;
                        end else if (!id_ok) begin
                            o_result.status = srfp_pkg::ST_BAD_ID;
                        end else begin
                            if (fresh) begin
                                n_seen[id_idx] = 1'b1;
                                n_count        = r_count + 1'b1;
                            end
                            o_result.new_servo   = fresh;
                            o_result.servo_total = n_count;
                            case (i_expected)
                                srfp_pkg::REPLY_POS: begin
                                    if (frame_total != srfp_pkg::POS_TOTAL) begin
                                        o_result.status = srfp_pkg::ST_BAD_LEN;
                                    end else begin
                                        o_result.status   = srfp_pkg::ST_POS_OK;
                                        o_result.position = pos_val;
                                    end
                                end
                                srfp_pkg::REPLY_ACK: begin
                                    if (frame_total != srfp_pkg::ACK_TOTAL) begin
                                        o_result.status = srfp_pkg::ST_BAD_LEN;
                                    end else begin
                                        o_result.status     = srfp_pkg::ST_ACK_OK;
                                        o_result.error_bits = r_status_byte;
                                    end
                                end
                                default: begin
                                    o_result.status = srfp_pkg::ST_PING;
                                end
                            endcase
                        end
                    end else begin
                        case (r_index)
                            8'd0:    n_status_byte = i_byte;
                            8'd1:    n_pos_lo      = i_byte;
                            8'd2:    n_pos_hi      = i_byte;
                            default: n_status_byte = r_status_byte;
                        endcase
                        n_sum   = r_sum + i_byte;
                        n_index = r_index + 8'd1;
                    end
                end
                default: begin
                    n_phase = srfp_pkg::PH_HUNT1;
                    n_index = '0;
                    n_sum   = '0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/servo_reply_frame_parser_core.sv =====
// Top level of the servo reply frame parser: input register, result register, APB register.
//
//  channel   direction  handshake        payload
//  i_rx      in         valid/ready      rx_byte[7:0], flush
//  o_status  out        valid/ready      status, servo_id, error_bits, position,
//                                        new_servo, servo_total
//  APB       in         psel/penable     expected_reply at byte address 0
//
// One byte is taken per cycle while the result register is free or being taken. A byte
// is held in the input register, decoded against the parser state, and its result
// (if any) is registered in the result register.
// Reset is synchronous and active low; it returns the parser to the header hunt and
// clears the seen-id mask and servo count. When the result register is full and not
// taken, the parser holds and the input register fills; no transaction is lost.
`default_nettype none
module servo_reply_frame_parser_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    srfp_rx_if.sink                             i_rx,
    srfp_status_if.source                       o_status,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [srfp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [srfp_pkg::PDATA_W-1:0]   pwdata,
    output logic      [srfp_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_flush;
    logic       r_out_valid;
    srfp_pkg::t_result r_out;
    logic [1:0] r_expected;

    logic advance;
    logic step;
    logic cfg_wr;
    srfp_pkg::t_result result;

    assign advance = !r_out_valid || o_status.ready;
    assign step    = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte  <= i_rx.rx_byte;
            r_in_flush <= i_rx.flush;
        end
    end

    srfp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_flush    (r_in_flush),
        .i_expected (r_expected),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_out <= result;
        end
    end

    assign o_status.valid       = r_out_valid;
    assign o_status.status      = r_out.status;
    assign o_status.servo_id    = r_out.servo_id;
    assign o_status.error_bits  = r_out.error_bits;
    assign o_status.position    = r_out.position;
    assign o_status.new_servo   = r_out.new_servo;
    assign o_status.servo_total = r_out.servo_total;

    // APB: single register; the low two address bits are ignored by the decode.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[srfp_pkg::PADDR_W-1:2] == srfp_pkg::REG_EXPECTED_REPLY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= srfp_pkg::REPLY_PING;
        end else if (cfg_wr) begin
            r_expected <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[srfp_pkg::PADDR_W-1:2] == srfp_pkg::REG_EXPECTED_REPLY) begin
            prdata[1:0] = r_expected;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_servo_reply_frame_parser_core.sv =====
// Self-checking testbench for the servo reply frame parser core.
import srfp_pkg::*;

typedef struct {
    logic [2:0]         status;
    logic [7:0]         servo_id;
    logic [7:0]         error_bits;
    logic [15:0]        position;
    logic               new_servo;
    logic [COUNT_W-1:0] servo_total;
} status_rec_t;

// Tracks the parser state byte by byte and holds the status results still to come.
class reply_status_tracker;
    t_reply             reply_kind;
    t_phase             phase;
    logic [7:0]         ident;
    logic [7:0]         len_field;
    logic [7:0]         body_pos;
    logic [7:0]         sum;
    logic [7:0]         err_byte;
    logic [7:0]         pos_lo;
    logic [7:0]         pos_hi;
    logic [31:0]        seen_ids;
    logic [COUNT_W-1:0] seen_total;
    status_rec_t        awaited_status[$];
    int                 mismatches;

    function new();
        reply_kind = REPLY_PING;
        ident      = '0;
        len_field  = '0;
        err_byte   = '0;
        pos_lo     = '0;
        pos_hi     = '0;
        seen_ids   = '0;
        seen_total = '0;
        mismatches = 0;
        restart_hunt();
    endfunction

    function void restart_hunt();
        phase    = PH_HUNT1;
        body_pos = '0;
        sum      = '0;
    endfunction

    function void expect_status(t_status st, logic [7:0] err, logic [15:0] pos, logic fresh);
        status_rec_t rec;
        rec.status      = st;
        rec.servo_id    = ident;
        rec.error_bits  = err;
        rec.position    = pos;
        rec.new_servo   = fresh;
        rec.servo_total = seen_total;
        awaited_status.push_back(rec);
    endfunction

    function void close_frame(logic [7:0] check);
        logic [8:0]  total;
        logic [7:0]  want;
        logic        fresh;
        logic [15:0] raw;
        logic [15:0] mag;
        total = {1'b0, len_field} + FRAME_OVERHEAD;
        want  = ~sum;
        fresh = 1'b0;
        restart_hunt();
        if (check != want) begin
            expect_status(ST_BAD_CSUM, 8'h00, 16'h0000, 1'b0);
            return;
        end
        if (ident < 1 || ident > SERVO_CHANNELS) begin
            expect_status(ST_BAD_ID, 8'h00, 16'h0000, 1'b0);
            return;
        end
        // The id is marked before the length is judged against the reply kind.
        if (!seen_ids[ident - 8'd1]) begin
            seen_ids[ident - 8'd1] = 1'b1;
            seen_total = seen_total + 1'b1;
            fresh = 1'b1;
        end
        case (reply_kind)
            REPLY_POS: begin
                if (total != POS_TOTAL) begin
                    expect_status(ST_BAD_LEN, 8'h00, 16'h0000, fresh);
                end else begin
                    raw = {pos_hi, pos_lo};
                    mag = {1'b0, raw[14:0]};
                    expect_status(ST_POS_OK, 8'h00, raw[15] ? 16'h0000 - mag : mag, fresh);
                end
            end
            REPLY_ACK: begin
                if (total != ACK_TOTAL)
                    expect_status(ST_BAD_LEN, 8'h00, 16'h0000, fresh);
                else
                    expect_status(ST_ACK_OK, err_byte, 16'h0000, fresh);
            end
            default: begin
                expect_status(ST_PING, 8'h00, 16'h0000, fresh);
            end
        endcase
    endfunction

    function void parse_byte(logic [7:0] b, logic flush);
        logic [8:0] total;
        if (flush) begin
            restart_hunt();
            return;
        end
        case (phase)
            PH_HUNT1: begin
                if (b == HEADER_BYTE)
                    phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                phase = (b == HEADER_BYTE) ? PH_ID : PH_HUNT1;
            end
            PH_ID: begin
                ident = b;
                sum   = b;
                phase = PH_LEN;
            end
            PH_LEN: begin
                len_field = b;
                sum       = sum + b;
                total     = {1'b0, b} + FRAME_OVERHEAD;
                if (total > MAX_TOTAL) begin
                    restart_hunt();
                    expect_status(ST_OVERSIZE, 8'h00, 16'h0000, 1'b0);
                end else if (total < MIN_TOTAL) begin
                    restart_hunt();
                    expect_status(ST_BAD_LEN, 8'h00, 16'h0000, 1'b0);
                end else begin
                    body_pos = '0;
                    phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                if ({1'b0, body_pos} + 9'd1 >= {1'b0, len_field}) begin
                    close_frame(b);
                end else begin
                    case (body_pos)
                        8'd0: err_byte = b;
                        8'd1: pos_lo = b;
                        8'd2: pos_hi = b;
                        default: ;
                    endcase
                    sum      = sum + b;
                    body_pos = body_pos + 8'd1;
                end
            end
            default: begin
                restart_hunt();
            end
        endcase
    endfunction

    function void report(string field, logic [15:0] want_v, logic [15:0] got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        mismatches++;
    endfunction

    function void check_status(status_rec_t got);
        status_rec_t want;
        if (awaited_status.size() == 0) begin
            $display("%0t: status %0d for id %0d arrived with none expected",
                     $time, got.status, got.servo_id);
            mismatches++;
            return;
        end
        want = awaited_status.pop_front();
        if (got.status !== want.status)
            report("status", want.status, got.status);
        if (got.servo_id !== want.servo_id)
            report("servo_id", want.servo_id, got.servo_id);
        if (got.error_bits !== want.error_bits)
            report("error_bits", want.error_bits, got.error_bits);
        if (got.position !== want.position)
            report("position", want.position, got.position);
        if (got.new_servo !== want.new_servo)
            report("new_servo", want.new_servo, got.new_servo);
        if (got.servo_total !== want.servo_total)
            report("servo_total", want.servo_total, got.servo_total);
    endfunction
endclass

module tb_servo_reply_frame_parser_core;
    typedef struct {
        logic [7:0] data;
        logic       flush;
    } rx_item_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    srfp_rx_if     rx_ch();
    srfp_status_if status_ch();

    reply_status_tracker tracker = new();
    rx_item_t            byte_plan[$];
    int                  results_seen = 0;
    bit                  no_idle = 1'b0;

    servo_reply_frame_parser_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (rx_ch),
        .o_status (status_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #6000000;
        $display("FAIL servo_reply_frame_parser_core");
        $finish;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void add_item(logic [7:0] data, logic flush);
        rx_item_t it;
        it.data  = data;
        it.flush = flush;
        byte_plan.push_back(it);
    endfunction

    function automatic void add_head(logic [7:0] id, logic [7:0] len);
        add_item(HEADER_BYTE, 1'b0);
        add_item(HEADER_BYTE, 1'b0);
        add_item(id, 1'b0);
        add_item(len, 1'b0);
    endfunction

    // Whole frame; the body starts with the error byte and the position word.
    function automatic void add_frame(logic [7:0] id, logic [7:0] len, logic [7:0] err,
                                      logic [15:0] raw, bit corrupt);
        logic [7:0] sum;
        logic [7:0] d;
        add_head(id, len);
        sum = id + len;
        for (int i = 0; i + 1 < len; i++) begin
            d = (i == 0) ? err : (i == 1) ? raw[7:0] : (i == 2) ? raw[15:8] : 8'($urandom);
            sum = sum + d;
            add_item(d, 1'b0);
        end
        add_item(~sum ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00), 1'b0);
    endfunction

    function automatic logic [7:0] frame_len(t_reply kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            REPLY_POS: return (r < 80) ? 8'd4 : 8'($urandom_range(2, 8));
            REPLY_ACK: return (r < 80) ? 8'd2 : 8'($urandom_range(2, 8));
            default:   return (r < 85) ? 8'($urandom_range(2, 12))
                                       : 8'($urandom_range(13, MAX_FRAME_BYTES - 4));
        endcase
    endfunction

    // Queues one random chunk of traffic and returns how many bytes it added.
    function automatic int add_random_traffic(t_reply kind);
        int          r;
        int          start_size;
        int          cut;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [15:0] raw;
        start_size = byte_plan.size();
        r      = $urandom_range(0, 99);
        id     = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(1, SERVO_CHANNELS));
        len    = frame_len(kind);
        case ($urandom_range(0, 9))
            0:       raw = 16'h7FFF;
            1:       raw = 16'h8000;
            2:       raw = 16'hFFFF;
            default: raw = 16'($urandom);
        endcase
        if (r < 60) begin
            add_frame(id, len, 8'($urandom), raw, 1'b0);
        end else if (r < 70) begin
            add_frame(id, len, 8'($urandom), raw, 1'b1);
        end else if (r < 76) begin
            add_head(id, 8'($urandom_range(MAX_FRAME_BYTES - 3, 255)));
        end else if (r < 80) begin
            add_head(id, 8'($urandom_range(0, 1)));
        end else if (r < 88) begin
            // Frame cut short and abandoned by a flush.
            add_frame(id, len, 8'($urandom), raw, 1'b0);
            cut = $urandom_range(start_size + 1, byte_plan.size() - 1);
            byte_plan = byte_plan[0:cut-1];
            add_item(8'($urandom), 1'b1);
        end else begin
            if ($urandom_range(0, 1) == 1)
                add_item(HEADER_BYTE, 1'b0);
            repeat ($urandom_range(1, 4)) add_item(8'($urandom_range(0, 254)), 1'b0);
        end
        return byte_plan.size() - start_size;
    endfunction

    task automatic push_item(rx_item_t it);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= it.data;
        rx_ch.flush   <= it.flush;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        tracker.parse_byte(it.data, it.flush);
    endtask

    task automatic play_plan();
        foreach (byte_plan[k]) push_item(byte_plan[k]);
        byte_plan.delete();
    endtask

    // Bytes that yield no status may still be in the pipe after the last result.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (tracker.awaited_status.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reply(t_reply kind);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_EXPECTED_REPLY, 2'b00};
        pwdata  <= PDATA_W'(kind);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.reply_kind = kind;
    endtask

    // Result side: checks every status transaction and applies back-pressure.
    initial begin
        status_rec_t got;
        int          stall_left;
        int          hold_at;
        logic        nxt;
        stall_left = 0;
        hold_at    = 40;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && status_ch.valid && status_ch.ready) begin
                got.status      = status_ch.status;
                got.servo_id    = status_ch.servo_id;
                got.error_bits  = status_ch.error_bits;
                got.position    = status_ch.position;
                got.new_servo   = status_ch.new_servo;
                got.servo_total = status_ch.servo_total;
                tracker.check_status(got);
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b0;
            end else if (results_seen >= hold_at) begin
                // A long hold lets the result and input registers fill up.
                stall_left = 120;
                hold_at    = (hold_at == 40) ? 400 : (1 << 30);
                nxt        = 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                nxt        = 1'b0;
            end else begin
                nxt = 1'b1;
            end
            status_ch.ready <= nxt;
        end
    end

    initial begin
        t_reply kind;
        int     phase_no;
        int     phase_items;
        int     random_items;
        i_rst_n         <= 1'b0;
        rx_ch.valid     <= 1'b0;
        rx_ch.rx_byte   <= '0;
        rx_ch.flush     <= 1'b0;
        status_ch.ready <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reply(REPLY_PING);
        add_item(HEADER_BYTE, 1'b0);
        add_item(8'h00, 1'b0);
        add_frame(8'd1, 8'd2, 8'h00, 16'h0000, 1'b0);
        add_item(HEADER_BYTE, 1'b1);
        add_head(8'd3, 8'd255);
        add_head(8'd3, 8'(MAX_FRAME_BYTES - 3));
        add_head(8'd4, 8'd0);
        add_head(8'd4, 8'd1);
        add_frame(8'd0, 8'd2, 8'h00, 16'h0000, 1'b0);
        add_frame(8'hFF, 8'd2, 8'h00, 16'h0000, 1'b0);
        add_frame(8'd2, 8'd2, 8'h00, 16'h0000, 1'b1);
        add_frame(8'd5, 8'(MAX_FRAME_BYTES - 4), 8'h00, 16'h0000, 1'b0);
        play_plan();
        drain();

        write_reply(REPLY_ACK);
        add_frame(8'(SERVO_CHANNELS), 8'd2, 8'hFF, 16'h0000, 1'b0);
        add_frame(8'd6, 8'd3, 8'h01, 16'h0000, 1'b0);
        play_plan();
        drain();

        write_reply(REPLY_POS);
        add_frame(8'd7, 8'd4, 8'h00, 16'hFFFF, 1'b0);
        add_frame(8'd7, 8'd4, 8'h00, 16'h7FFF, 1'b0);
        add_frame(8'd8, 8'd4, 8'h00, 16'h8000, 1'b0);
        add_frame(8'd8, 8'd2, 8'h00, 16'h0000, 1'b0);
        play_plan();
        drain();

        write_reply(REPLY_UNUSED);
        add_frame(8'd9, 8'd5, 8'h00, 16'h1234, 1'b0);
        play_plan();
        drain();

        phase_no     = 0;
        random_items = 0;
        while (random_items < 1000) begin
            kind    = t_reply'((phase_no * 3 + 2) % 4);
            no_idle = (phase_no % 3 == 2);
            write_reply(kind);
            phase_items = 0;
            while (phase_items < 150 && random_items + phase_items < 1000)
                phase_items += add_random_traffic(kind);
            random_items += phase_items;
            play_plan();
            drain();
            phase_no++;
        end

        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.awaited_status.size() == 0) begin
            $display("PASS servo_reply_frame_parser_core");
        end else begin
            $display("FAIL servo_reply_frame_parser_core");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/srfp_pkg.sv
hw/rtl/srfp_if.sv
hw/rtl/srfp_parser.sv
hw/rtl/servo_reply_frame_parser_core.sv
tb/sv/tb_servo_reply_frame_parser_core.sv
